// ----- hw/rtl/pdm_pkg.sv -----
// Shared types and constants for the pixel to DMX channel mapper.
// Used by pdm_front, pdm_fifo, pdm_back and pixel_to_dmx_channel_mapper.
// No dependencies.
package pdm_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_UNIVERSE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_PER_PIXEL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_UNIVERSE    = 2'd3;

    // DMX limits.
    localparam logic [8:0]  LAST_CHANNEL   = 9'd511;
    localparam logic [14:0] UNIVERSE_MAX   = 15'h7FFF;
    localparam logic [2:0]  CPP_RESET      = 3'd3;
    localparam logic [2:0]  CPP_MIN        = 3'd1;
    localparam logic [2:0]  CPP_MAX        = 3'd4;

    // Configuration registers as seen by front and back.
    typedef struct packed {
        logic [14:0] start_universe;
        logic [8:0]  start_address;
        logic [2:0]  channels_per_pixel;
        logic [14:0] target_universe;
    } t_cfg;

    // One classified pixel waiting for the back end.
    typedef struct packed {
        logic [3:0][7:0] bytes;     // index 0 is red
        logic [2:0]      count;     // 1..4 bytes to emit
        logic [15:0]     universe;  // universe of the first byte, may be 32768
        logic [8:0]      channel;   // channel of the first byte
    } t_job;

    // One result beat.
    typedef struct packed {
        logic [14:0] universe;
        logic [8:0]  channel;
        logic [7:0]  value;
        logic        in_target;
        logic        past_limit;
        logic        last_of_pixel;
    } t_beat;

    // Queue status toward front, back and checks.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

// ----- hw/rtl/pdm_front.sv -----
// Front end: accepts pixels, resolves each pixel's start position and
// advances the running position by the pixel's byte count. Uses pdm_pkg.
module pdm_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdm_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    input  logic [31:0]         i_data,
    input  logic                i_first_pixel,
    output logic                o_ready,
    input  pdm_pkg::t_fifo_status i_fifo,
    output logic                o_push,
    output pdm_pkg::t_job       o_job
);

    logic [15:0] r_cur_universe, n_cur_universe;
    logic [8:0]  r_cur_channel, n_cur_channel;
    logic        r_pos_valid, n_pos_valid;

    logic        load;
    logic [15:0] base_universe;
    logic [8:0]  base_channel;
    logic [2:0]  count;
    logic [9:0]  ch_sum;

    // A pixel is taken whenever the queue has room.
    assign o_ready = !i_fifo.full;
    assign o_push  = i_valid && o_ready;

    // Clamp the channel count to the range one to four.
    always_comb begin
        if (i_cfg.channels_per_pixel < pdm_pkg::CPP_MIN) begin
            count = pdm_pkg::CPP_MIN;
        end else if (i_cfg.channels_per_pixel > pdm_pkg::CPP_MAX) begin
            count = pdm_pkg::CPP_MAX;
        end else begin
            count = i_cfg.channels_per_pixel;
        end
    end

    // Start position of this pixel: reload from the registers on a first
    // pixel or when no position has been loaded yet.
    assign load          = i_first_pixel || !r_pos_valid;
    assign base_universe = load ? {1'b0, i_cfg.start_universe} : r_cur_universe;
    assign base_channel  = load ? i_cfg.start_address : r_cur_channel;
    assign ch_sum        = {1'b0, base_channel} + {7'd0, count};

    always_comb begin
        o_job.bytes    = i_data;
        o_job.count    = count;
        o_job.universe = base_universe;
        o_job.channel  = base_channel;
    end

    // Advance by the whole pixel; four bytes cross a universe edge at most once.
    // A universe past the limit stays at 32768.
    always_comb begin
        n_cur_universe = r_cur_universe;
        n_cur_channel  = r_cur_channel;
        n_pos_valid    = r_pos_valid;
        if (o_push) begin
            n_pos_valid = 1'b1;
            if (ch_sum[9]) begin
                n_cur_channel  = ch_sum[8:0];
                n_cur_universe = base_universe[15] ? base_universe
                                                   : base_universe + 16'd1;
            end else begin
                n_cur_channel  = ch_sum[8:0];
                n_cur_universe = base_universe;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_universe <= '0;
            r_cur_channel  <= '0;
            r_pos_valid    <= 1'b0;
        end else begin
            r_cur_universe <= n_cur_universe;
            r_cur_channel  <= n_cur_channel;
            r_pos_valid    <= n_pos_valid;
        end
    end

endmodule

// ----- hw/rtl/pdm_fifo.sv -----
// Short queue of classified pixels between front and back end.
// Uses pdm_pkg for the job type and status struct.
module pdm_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pdm_pkg::t_job         i_job,
    input  logic                  i_pop,
    output pdm_pkg::t_job         o_job,
    output pdm_pkg::t_fifo_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pdm_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    logic do_push, do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Pointer and fill count update with explicit wrap.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- hw/rtl/pdm_back.sv -----
// Back end: walks the bytes of the queued pixel, one beat per cycle while the
// output register is free, tags each with universe, channel and flags. Uses pdm_pkg.
module pdm_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [14:0]           i_target_universe,
    input  pdm_pkg::t_job         i_job,
    input  pdm_pkg::t_fifo_status i_fifo,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output pdm_pkg::t_beat        o_beat
);

    logic [1:0]     r_k, n_k;
    logic [15:0]    r_universe, n_universe;
    logic [8:0]     r_channel, n_channel;
    logic           r_valid, n_valid;
    pdm_pkg::t_beat r_beat, n_beat;

    logic        emit;
    logic        last;
    logic        past;
    logic [15:0] cur_universe;
    logic [8:0]  cur_channel;
    logic [14:0] out_universe;

    // A byte is produced when a pixel waits and the output register is free.
    assign emit = !i_fifo.empty && (!r_valid || i_ready);
    assign last = (({1'b0, r_k}) + 3'd1) == i_job.count;
    assign o_pop = emit && last;

    // The first byte of a pixel starts at the queued position.
    assign cur_universe = (r_k == 2'd0) ? i_job.universe : r_universe;
    assign cur_channel  = (r_k == 2'd0) ? i_job.channel : r_channel;
    assign past         = cur_universe[15];
    assign out_universe = past ? pdm_pkg::UNIVERSE_MAX : cur_universe[14:0];

    always_comb begin
        n_beat.universe      = out_universe;
        n_beat.channel       = cur_channel;
        n_beat.value         = i_job.bytes[r_k];
        n_beat.in_target     = !past && (out_universe == i_target_universe);
        n_beat.past_limit    = past;
        n_beat.last_of_pixel = last;
    end

    // Byte index and running position.
    always_comb begin
        n_k        = r_k;
        n_universe = r_universe;
        n_channel  = r_channel;
        if (emit) begin
            n_k = last ? 2'd0 : r_k + 2'd1;
            if (cur_channel == pdm_pkg::LAST_CHANNEL) begin
                n_channel  = '0;
                n_universe = past ? cur_universe : cur_universe + 16'd1;
            end else begin
                n_channel  = cur_channel + 9'd1;
                n_universe = cur_universe;
            end
        end
    end

    // Output register valid flag.
    always_comb begin
        if (emit) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_k     <= n_k;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_universe <= n_universe;
        r_channel  <= n_channel;
        if (emit) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ----- hw/rtl/pixel_to_dmx_channel_mapper.sv -----
// Top level of the pixel to DMX channel mapper: configuration registers,
// front end, pixel queue and back end. Uses pdm_pkg, pdm_front, pdm_fifo, pdm_back.
//
// Channel  Dir  Fields (lowest bit first)
// s_axis   in   tdata: red, green, blue, white; tuser: first_pixel
// m_axis   out  tdata: universe, channel, value; tuser: in_target,
//               past_limit; tlast: last_of_pixel
// cfg      in   i_cfg_we, i_cfg_addr (register index), i_cfg_wdata
//
// A pixel yields channels_per_pixel beats, clamped to one to four, one per
// cycle while m_axis_tready does not hold the output. Pixels are taken while the
// queue has room, also while a beat waits on m_axis_tready. Reset is
// synchronous and clears position and queue.
module pixel_to_dmx_channel_mapper #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pdm_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [pdm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,  // red, green, blue, white
    input  logic                             s_axis_tuser,  // first_pixel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // universe, channel, value
    output logic [1:0]                       m_axis_tuser,  // in_target, past_limit
    output logic                             m_axis_tlast   // last_of_pixel
);

    pdm_pkg::t_cfg        r_cfg;
    pdm_pkg::t_fifo_status fifo_status;
    pdm_pkg::t_job        push_job;
    pdm_pkg::t_job        head_job;
    pdm_pkg::t_beat       beat;
    logic                 push;
    logic                 pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_universe     <= '0;
            r_cfg.start_address      <= '0;
            r_cfg.channels_per_pixel <= pdm_pkg::CPP_RESET;
            r_cfg.target_universe    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pdm_pkg::REG_START_UNIVERSE: begin
                    r_cfg.start_universe <= i_cfg_wdata[14:0];
                end
                pdm_pkg::REG_START_ADDRESS: begin
                    r_cfg.start_address <= i_cfg_wdata[8:0];
                end
                pdm_pkg::REG_CHANNELS_PER_PIXEL: begin
                    r_cfg.channels_per_pixel <= i_cfg_wdata[2:0];
                end
                pdm_pkg::REG_TARGET_UNIVERSE: begin
                    r_cfg.target_universe <= i_cfg_wdata[14:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front end classifies pixels.
    pdm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .i_data        (s_axis_tdata),
        .i_first_pixel (s_axis_tuser),
        .o_ready       (s_axis_tready),
        .i_fifo        (fifo_status),
        .o_push        (push),
        .o_job         (push_job)
    );

    // Queue between the two halves.
    pdm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (fifo_status)
    );

    // Back end emits bytes.
    pdm_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_target_universe (r_cfg.target_universe),
        .i_job             (head_job),
        .i_fifo            (fifo_status),
        .o_pop             (pop),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_beat            (beat)
    );

    // Pack the result beat.
    assign m_axis_tdata = {beat.value, beat.channel, beat.universe};
    assign m_axis_tuser = {beat.past_limit, beat.in_target};
    assign m_axis_tlast = beat.last_of_pixel;

    // Checks.
    a_fifo_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_status.full && fifo_status.empty))
        else $error("queue reports full and empty at once");

    a_past_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
            (m_axis_tdata[14:0] == pdm_pkg::UNIVERSE_MAX) && !m_axis_tuser[0])
        else $error("beat past the universe limit is not saturated");

    a_pop_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> m_axis_tvalid && m_axis_tlast)
        else $error("pixel left the queue without its last beat");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule
